@@ sv/smsd_pkg.sv @@
// ----------------------------------------------------------------------------
// smsd_pkg
// Types shared by the sample mean and deviation core.
// ----------------------------------------------------------------------------
package smsd_pkg;

    typedef struct packed {
        logic signed [15:0] sample;
        logic               is_last;
    } smsd_in_t;

    typedef struct packed {
        logic signed [15:0] mean;
        logic        [15:0] std_dev;
        logic        [10:0] sample_count;
        logic               overflow;
    } smsd_out_t;

    // Request to and status from the shared divider.
    typedef struct packed {
        logic        start;
        logic [63:0] dividend;
        logic [16:0] divisor;
    } smsd_div_req_t;

    typedef struct packed {
        logic        done;
        logic [63:0] quotient;
    } smsd_div_rsp_t;

endpackage

@@ sv/smsd_div.sv @@
// ----------------------------------------------------------------------------
// smsd_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module smsd_div
    import smsd_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  smsd_div_req_t req,
    output smsd_div_rsp_t rsp
);

    logic        busy_reg;
    logic [5:0]  cnt_reg;
    logic [63:0] quo_reg;
    logic [17:0] rem_reg;
    logic [16:0] dvs_reg;
    logic [17:0] trial;
    logic        done_reg;

    assign trial = {rem_reg[16:0], quo_reg[63]};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 6'd1;
                if (cnt_reg == 6'd63)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            quo_reg <= req.dividend;
            rem_reg <= '0;
            dvs_reg <= req.divisor;
        end
        else if (busy_reg)
        begin
            if (trial >= {1'b0, dvs_reg})
            begin
                rem_reg <= trial - {1'b0, dvs_reg};
                quo_reg <= {quo_reg[62:0], 1'b1};
            end
            else
            begin
                rem_reg <= trial;
                quo_reg <= {quo_reg[62:0], 1'b0};
            end
        end
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = quo_reg;

endmodule

@@ sv/smsd_sqrt.sv @@
// ----------------------------------------------------------------------------
// smsd_sqrt
// Bitwise integer square root of a 64-bit value, one root bit per cycle.
// ----------------------------------------------------------------------------
module smsd_sqrt
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [63:0] value,
    output logic        done,
    output logic [31:0] root
);

    logic        busy_reg;
    logic [4:0]  cnt_reg;
    logic [63:0] v_reg;
    logic [63:0] r_reg;
    logic [63:0] b_reg;
    logic [63:0] sum;
    logic        done_reg;

    assign sum = r_reg + b_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 5'd1;
                if (cnt_reg == 5'd31)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Starting the bit at the top is equivalent to skipping the oversized bits.
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            v_reg <= value;
            r_reg <= '0;
            b_reg <= 64'h4000_0000_0000_0000;
        end
        else if (busy_reg)
        begin
            if (v_reg >= sum)
            begin
                v_reg <= v_reg - sum;
                r_reg <= (r_reg >> 1) + b_reg;
            end
            else
            begin
                r_reg <= r_reg >> 1;
            end
            b_reg <= b_reg >> 2;
        end
    end

    assign done = done_reg;
    assign root = r_reg[31:0];

endmodule

@@ sv/sample_mean_stddev_core.sv @@
// ----------------------------------------------------------------------------
// sample_mean_stddev_core
// Population mean and standard deviation of a set of signed Q8.8 samples.
// ----------------------------------------------------------------------------
//  Channel | Direction | Payload     | Handshake
//  in      | input     | smsd_in_t   | in_valid / in_stall
//  out     | output    | smsd_out_t  | out_valid / out_stall
//
//  A sample that is not last is written to the store, or dropped and flagged
//  if the store is full. A last sample of a set starts its result word: the
//  shared 64-step divider is used twice (mean, then variance), the store is
//  read once per sample, and the square root takes 32 steps. A single sample
//  skips the square root. Reset clears the counters and flags; the store
//  needs no clearing. While a result waits under out_stall, the next set
//  may begin loading, but its last sample is held off.
// ----------------------------------------------------------------------------
module sample_mean_stddev_core
    import smsd_pkg::*;
#(
    parameter int MAX_SAMPLES = 1024
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_stall,
    input  smsd_in_t  in_data,
    output logic      out_valid,
    input  logic      out_stall,
    output smsd_out_t out_data
);

    localparam int AW = (MAX_SAMPLES > 1) ? $clog2(MAX_SAMPLES) : 1;
    localparam int CW = $clog2(MAX_SAMPLES + 1);

    localparam logic [2:0] S_LOAD  = 3'd0;
    localparam logic [2:0] S_MDIV  = 3'd1;
    localparam logic [2:0] S_READ  = 3'd2;
    localparam logic [2:0] S_ACC   = 3'd3;
    localparam logic [2:0] S_VDIV  = 3'd4;
    localparam logic [2:0] S_SQRT  = 3'd5;
    localparam logic [2:0] S_EMIT  = 3'd6;

    logic [2:0]        state_reg;
    logic signed [15:0] store [MAX_SAMPLES];
    logic signed [15:0] rd_reg;
    logic signed [39:0] sum_reg;
    logic [CW-1:0]      cnt_reg;
    logic [CW-1:0]      idx_reg;
    logic               drop_reg;
    logic [63:0]        sq_reg;
    logic signed [16:0] mean_reg;
    logic               neg_reg;
    logic               rd_ok_reg;
    logic               out_valid_reg;
    smsd_out_t          out_reg;

    smsd_div_req_t div_req;
    smsd_div_rsp_t div_rsp;
    logic          sq_start;
    logic          sq_done;
    logic [31:0]   sq_root;

    logic          accept;
    logic          room;
    logic [39:0]   abs_sum;
    logic signed [17:0] diff;
    logic [16:0]   adiff;
    logic [33:0]   adiff_sq;
    logic [63:0]   q_signed;

    assign room     = cnt_reg < CW'(MAX_SAMPLES);
    assign in_stall = (state_reg != S_LOAD) || (out_valid_reg && in_data.is_last);
    assign accept   = in_valid && !in_stall;
    assign abs_sum  = sum_reg[39] ? 40'(-sum_reg) : 40'(sum_reg);
    assign diff     = 18'(rd_reg) - 18'(mean_reg);
    assign adiff    = diff[17] ? 17'(-diff) : 17'(diff);
    assign adiff_sq = 34'(adiff) * 34'(adiff);
    assign q_signed = neg_reg ? -div_rsp.quotient : div_rsp.quotient;

    // The divider is shared: first for the mean, later for the variance.
    always_comb
    begin
        div_req.start    = 1'b0;
        div_req.dividend = {24'd0, abs_sum};
        div_req.divisor  = 17'(cnt_reg);
        if (accept && in_data.is_last)
        begin
            div_req.start = 1'b1;
            if (room)
            begin
                if (!((sum_reg + 40'(in_data.sample)) < 0))
                    div_req.dividend = 64'(sum_reg + 40'(in_data.sample));
                else
                    div_req.dividend = 64'(40'(-(sum_reg + 40'(in_data.sample))));
                div_req.divisor = 17'(cnt_reg + CW'(1));
            end
        end
        else if (state_reg == S_ACC && !rd_ok_reg && idx_reg == cnt_reg)
        begin
            div_req.start    = 1'b1;
            div_req.dividend = sq_reg;
        end
    end

    smsd_div u_div
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    assign sq_start = (state_reg == S_VDIV) && div_rsp.done && (cnt_reg > CW'(1));

    smsd_sqrt u_sqrt
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (sq_start),
        .value (div_rsp.quotient),
        .done  (sq_done),
        .root  (sq_root)
    );

    always_ff @(posedge clk)
    begin
        if (accept && room)
            store[cnt_reg[AW-1:0]] <= in_data.sample;
        rd_reg <= store[idx_reg[AW-1:0]];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_LOAD;
            sum_reg       <= '0;
            cnt_reg       <= '0;
            idx_reg       <= '0;
            drop_reg      <= 1'b0;
            sq_reg        <= '0;
            mean_reg      <= '0;
            neg_reg       <= 1'b0;
            rd_ok_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (out_valid_reg && !out_stall)
                out_valid_reg <= 1'b0;
            unique case (state_reg)
                S_LOAD:
                begin
                    if (accept)
                    begin
                        if (room)
                        begin
                            sum_reg <= sum_reg + 40'(in_data.sample);
                            cnt_reg <= cnt_reg + CW'(1);
                            neg_reg <= (sum_reg + 40'(in_data.sample)) < 0;
                        end
                        else
                        begin
                            drop_reg <= 1'b1;
                            neg_reg  <= sum_reg[39];
                        end
                        if (in_data.is_last)
                            state_reg <= S_MDIV;
                    end
                end
                S_MDIV:
                begin
                    if (div_rsp.done)
                    begin
                        mean_reg  <= 17'(q_signed);
                        idx_reg   <= '0;
                        sq_reg    <= '0;
                        state_reg <= S_READ;
                    end
                end
                S_READ:
                begin
                    // Address is presented; data arrives next cycle.
                    idx_reg   <= idx_reg + CW'(1);
                    rd_ok_reg <= 1'b1;
                    state_reg <= S_ACC;
                end
                S_ACC:
                begin
                    if (rd_ok_reg)
                    begin
                        sq_reg <= sq_reg + 64'(adiff_sq);
                        if (idx_reg == cnt_reg)
                            rd_ok_reg <= 1'b0;
                        else
                            idx_reg <= idx_reg + CW'(1);
                    end
                    else
                        state_reg <= S_VDIV;
                end
                S_VDIV:
                begin
                    if (div_rsp.done)
                    begin
                        if (cnt_reg > CW'(1))
                            state_reg <= S_SQRT;
                        else
                        begin
                            out_reg.std_dev <= '0;
                            state_reg       <= S_EMIT;
                        end
                    end
                end
                S_SQRT:
                begin
                    if (sq_done)
                    begin
                        out_reg.std_dev <= (sq_root > 32'hFFFF) ? 16'hFFFF : sq_root[15:0];
                        state_reg       <= S_EMIT;
                    end
                end
                S_EMIT:
                begin
                    if (!out_valid_reg || !out_stall)
                    begin
                        out_valid_reg        <= 1'b1;
                        out_reg.mean         <= mean_reg[15:0];
                        out_reg.sample_count <= 11'(cnt_reg);
                        out_reg.overflow     <= drop_reg;
                        sum_reg              <= '0;
                        cnt_reg              <= '0;
                        drop_reg             <= 1'b0;
                        state_reg            <= S_LOAD;
                    end
                end
                default:
                    state_reg <= S_LOAD;
            endcase
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

endmodule

@@ sv/smsd_checker.sv @@
// ----------------------------------------------------------------------------
// smsd_checker
// Port-level checks for the sample mean and deviation core.
// ----------------------------------------------------------------------------
module smsd_checker
    import smsd_pkg::*;
(
    input logic      clk,
    input logic      rst_n,
    input logic      in_valid,
    input logic      in_stall,
    input smsd_in_t  in_data,
    input logic      out_valid,
    input logic      out_stall,
    input smsd_out_t out_data
);

    // A result word never reports a count of zero.
    a_count: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> out_data.sample_count != 11'd0)
        else $error("zero sample count");

    // A stalled result holds its word.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_data))
        else $error("stalled result changed");

    // A last sample taken starts computation, so input stalls next cycle.
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && in_data.is_last |=> in_stall)
        else $error("input not stalled during computation");

endmodule

bind sample_mean_stddev_core smsd_checker u_smsd_checker
(
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
);

@@ sim/sample_mean_stddev_core_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sample_mean_stddev_core_tb
// Self-checking bench for the sample mean and deviation core. Sets of Q8.8
// samples are sent as input words. A local predictor works out the mean,
// deviation, count and overflow flag of each set. Every result word is
// compared, field by field, with the oldest prediction.
// ----------------------------------------------------------------------------
module sample_mean_stddev_core_tb;
    import smsd_pkg::*;

    localparam int  STORE_DEPTH = 1024;
    localparam int  CYCLE_LIMIT = 1000000;

    logic      clk;
    logic      rst_n;
    logic      in_valid;
    logic      in_stall;
    smsd_in_t  in_data;
    logic      out_valid;
    logic      out_stall;
    smsd_out_t out_data;

    // Predictor state: the samples of the set being loaded, its sum and
    // whether any sample was dropped because the store was full.
    logic signed [15:0] set_samples[$];
    longint             set_sum;
    bit                 set_dropped;

    // Predicted result words, oldest first.
    smsd_out_t          pending_results[$];

    int                 mismatches;
    int                 cycle_count;

    // Receiver controls. hold_cycles forces a long hold-off; quiet turns
    // off the random gaps and stalls on both sides.
    int                 hold_cycles;
    int                 stall_left;
    bit                 out_taken;
    bit                 quiet;

    sample_mean_stddev_core #(
        .MAX_SAMPLES (STORE_DEPTH)
    ) i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

    always #10 clk = ~clk;

    // Floor of the square root, worked out one result bit at a time.
    function automatic longint unsigned floor_sqrt(input longint unsigned v);
        longint unsigned root;
        longint unsigned b;
        root = 0;
        b = 64'd1 << 62;
        while (b > v)
            b = b >> 2;
        while (b != 0)
        begin
            if (v >= root + b)
            begin
                v = v - (root + b);
                root = (root >> 1) + b;
            end
            else
            begin
                root = root >> 1;
            end
            b = b >> 2;
        end
        return root;
    endfunction

    // Apply one accepted input word to the predictor. On the last sample of
    // a set the result word is predicted and the set state is cleared.
    task automatic predict_set_word(input smsd_in_t w);
        longint            mean;
        longint            diff;
        longint unsigned   sq_sum;
        longint unsigned   variance;
        longint unsigned   dev;
        smsd_out_t         r;
        if (set_samples.size() < STORE_DEPTH)
        begin
            set_samples.push_back(w.sample);
            set_sum += longint'(w.sample);
        end
        else
        begin
            set_dropped = 1'b1;
        end
        if (w.is_last)
        begin
            // Signed division truncates toward zero, as the mean requires.
            mean = set_sum / longint'(set_samples.size());
            sq_sum = 0;
            foreach (set_samples[i])
            begin
                diff = longint'(set_samples[i]) - mean;
                if (diff < 0)
                    diff = -diff;
                sq_sum += longint'(diff) * longint'(diff);
            end
            variance = sq_sum / longint'(set_samples.size());
            dev = (set_samples.size() > 1) ? floor_sqrt(variance) : 0;
            if (dev > 64'hFFFF)
                dev = 64'hFFFF;
            r.mean         = mean[15:0];
            r.std_dev      = dev[15:0];
            r.sample_count = 11'(set_samples.size());
            r.overflow     = set_dropped;
            pending_results.push_back(r);
            set_samples.delete();
            set_sum = 0;
            set_dropped = 1'b0;
        end
    endtask

    // Send one input word. Called at a falling edge; returns at the falling
    // edge after the word was accepted. The valid line is only lowered when
    // a gap is wanted, so it is never lowered and raised in the same step.
    task automatic send_word(input logic signed [15:0] s, input logic last);
        int gap;
        smsd_in_t w;
        gap = quiet ? 0 : $urandom_range(0, 16);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        w.sample  = s;
        w.is_last = last;
        in_valid <= 1'b1;
        in_data  <= w;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        predict_set_word(w);
        @(negedge clk);
    endtask

    // A random sample, with the extremes and zero drawn often.
    function automatic logic signed [15:0] pick_sample();
        case ($urandom_range(0, 7))
            0: return 16'sh8000;
            1: return 16'sh7FFF;
            2: return 16'sh0000;
            3: return 16'(-1);
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic send_set(input int n);
        for (int i = 0; i < n; i++)
            send_word(pick_sample(), i == n - 1);
    endtask

    // Single samples at the extremes and zero: the deviation must be zero.
    task automatic test_single_samples();
        send_word(16'sh8000, 1'b1);
        send_word(16'sh7FFF, 1'b1);
        send_word(16'sh0000, 1'b1);
    endtask

    // Extreme spreads, constant sets and means that truncate toward zero.
    task automatic test_directed_sets();
        send_word(16'sh7FFF, 1'b0);
        send_word(16'sh8000, 1'b1);
        repeat (3) send_word(16'sh8000, 1'b0);
        send_word(16'sh8000, 1'b1);
        send_word(16'(-1), 1'b0);
        send_word(16'sh0000, 1'b1);
        send_word(16'(-3), 1'b0);
        send_word(16'sh0000, 1'b1);
        send_word(16'sh0003, 1'b0);
        send_word(16'sh0000, 1'b1);
        send_word(16'sh7FFF, 1'b0);
        send_word(16'sh7FFF, 1'b0);
        send_word(16'sh8000, 1'b1);
    endtask

    // Store full: one set fills the store with alternating extremes, then
    // its tail, including its last sample, is dropped and flagged. The next
    // set must be clean.
    task automatic test_store_full();
        quiet = 1'b1;
        for (int i = 0; i < STORE_DEPTH + 3; i++)
        begin
            if (i < STORE_DEPTH)
                send_word((i % 2) ? 16'sh7FFF : 16'sh8000, 1'b0);
            else
                send_word(pick_sample(), i == STORE_DEPTH + 2);
        end
        quiet = 1'b0;
        send_set(2);
    endtask

    // The receiver holds off for a long stretch while sets keep coming, so
    // the core fills up and has to stall its input.
    task automatic test_back_pressure();
        hold_cycles = 3000;
        for (int i = 0; i < 6; i++)
            send_set(4);
    endtask

    // Mostly short sets with random content, now and then a longer one and
    // stretches with no gaps or stalls at all.
    task automatic test_random_sets();
        int sent;
        int n;
        sent = 0;
        while (sent < 400)
        begin
            quiet = ($urandom_range(0, 5) == 0);
            if ($urandom_range(0, 9) == 0)
                n = $urandom_range(17, 60);
            else
                n = $urandom_range(1, 16);
            send_set(n);
            sent += n;
        end
        quiet = 1'b0;
    endtask

    // Receiver: stall drawn per word, or a forced hold-off, changed at the
    // falling edge only.
    always @(negedge clk)
    begin
        if (hold_cycles > 0)
        begin
            out_stall <= 1'b1;
            hold_cycles <= hold_cycles - 1;
        end
        else if (out_taken)
        begin
            out_taken <= 1'b0;
            if (!quiet && $urandom_range(0, 1))
            begin
                out_stall <= 1'b1;
                stall_left <= $urandom_range(1, 16) - 1;
            end
            else
            begin
                out_stall <= 1'b0;
            end
        end
        else if (stall_left > 0)
        begin
            out_stall <= 1'b1;
            stall_left <= stall_left - 1;
        end
        else
        begin
            out_stall <= 1'b0;
        end
    end

    // Result checker: every accepted result word against the oldest
    // prediction. Fields are printed as mean/dev/count/overflow.
    always @(posedge clk)
    begin
        smsd_out_t exp_word;
        if (rst_n && out_valid && !out_stall)
        begin
            out_taken <= 1'b1;
            if (pending_results.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result word: mean %0d dev %0d count %0d ovf %0b",
                             out_data.mean, out_data.std_dev, out_data.sample_count,
                             out_data.overflow);
            end
            else
            begin
                exp_word = pending_results.pop_front();
                if (out_data.mean !== exp_word.mean
                    || out_data.std_dev !== exp_word.std_dev
                    || out_data.sample_count !== exp_word.sample_count
                    || out_data.overflow !== exp_word.overflow)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected %0d/%0d/%0d/%0b, got %0d/%0d/%0d/%0b",
                                 exp_word.mean, exp_word.std_dev, exp_word.sample_count,
                                 exp_word.overflow, out_data.mean, out_data.std_dev,
                                 out_data.sample_count, out_data.overflow);
                end
            end
        end
    end

    // Watchdog on the whole run.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("sample_mean_stddev_core_tb: FAIL");
            $finish;
        end
    end

    initial
    begin
        clk = 1'b0;
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_data = '0;
        out_stall = 1'b0;
        set_sum = 0;
        set_dropped = 1'b0;
        mismatches = 0;
        cycle_count = 0;
        hold_cycles = 0;
        stall_left = 0;
        out_taken = 1'b0;
        quiet = 1'b0;
        repeat (11) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_single_samples();
        test_directed_sets();
        test_store_full();
        test_back_pressure();
        test_random_sets();

        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        // Let any stray word show itself before the verdict.
        repeat (300) @(posedge clk);
        if (mismatches == 0)
            $display("sample_mean_stddev_core_tb: PASS");
        else
            $display("sample_mean_stddev_core_tb: FAIL");
        $finish;
    end

endmodule

@@ sim.f @@
sv/smsd_pkg.sv
sv/smsd_div.sv
sv/smsd_sqrt.sv
sv/sample_mean_stddev_core.sv
sv/smsd_checker.sv
sim/sample_mean_stddev_core_tb.sv
